// File: src/source_address_blocklist_filter_macros.svh
// Assertion macros for the source address blocklist filter.
// Used by the top level only; no other dependencies.
`ifndef SOURCE_ADDRESS_BLOCKLIST_FILTER_MACROS_SVH
`define SOURCE_ADDRESS_BLOCKLIST_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define SABF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sabf assertion failed");
`define SABF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sabf reset assertion failed");
`else
`define SABF_ASSERT(lbl, prop)
`define SABF_ASSERT_RST(lbl, prop)
`endif
`endif

// File: src/sabf_pkg.sv
// Shared types and constants of the source address blocklist filter.
// No dependencies.
package sabf_pkg;
  localparam int TABLE_ENTRIES = 16384;  // power of two
  localparam int MAX_PROBES    = 8;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(MAX_PROBES + 1);
  localparam int MEM_W = 33;             // valid bit over 32-bit key

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
  localparam logic [31:0] MASK_P24 = 32'hFFFF_FF00;
  localparam logic [31:0] MASK_P16 = 32'hFFFF_0000;
  localparam logic [31:0] MASK_P8  = 32'hFF00_0000;

  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] REASON_NONE  = 3'd0;
  localparam logic [2:0] REASON_SHORT = 3'd1;
  localparam logic [2:0] REASON_EXACT = 3'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  typedef struct packed {
    logic       drop;
    logic [2:0] reason;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [MEM_W-1:0] wdata;
  } mem_req_t;
endpackage

// File: src/source_address_blocklist_filter.sv
// Top level of the source address blocklist filter: config register,
// table RAM, sequencer and output register. Depends on sabf_pkg,
// sabf_ram, sabf_ctrl and the macros header.
//
//   channel | direction | handshake      | payload
//   in_     | input     | valid / stall  | cmd, frame_length, address_key
//   out_    | output    | valid / stall  | verdict_drop, match_reason, op_status
//   cfg_    | input     | valid / ready  | data (prefix_check_enable)
//
// After reset a clearing pass writes every table slot with in_stall high;
// cfg writes are taken throughout.
// One item at a time. Each hashed lookup runs hash, probe reads through the
// single RAM port, and evaluate; a check runs up to four lookups, an add or
// remove one lookup plus a table write when it inserts or clears an entry,
// and every item passes an accept state and an output state.
// A short frame or unused command goes from accept straight to output; the
// output register lets the next item in while a result waits on out_stall.
`include "source_address_blocklist_filter_macros.svh"
module source_address_blocklist_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_frame_length,
  input  logic [31:0] in_address_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict_drop,
  output logic [2:0]  out_match_reason,
  output logic [1:0]  out_op_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  logic [2:0] prefix_en_r;
  logic       out_valid_r;
  sabf_pkg::result_t  out_r, res;
  sabf_pkg::mem_req_t mem_req;
  logic [sabf_pkg::MEM_W-1:0] mem_rdata;
  logic out_free, res_load;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_en_r <= 3'd7;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) prefix_en_r <= cfg_data;
      if (res_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_r <= res;
  end

  sabf_ram #(
    .DEPTH(sabf_pkg::TABLE_ENTRIES),
    .WIDTH(sabf_pkg::MEM_W)
  ) u_ram (
    .clk(clk), .we(mem_req.we), .addr(mem_req.addr),
    .wdata(mem_req.wdata), .rdata(mem_rdata)
  );

  sabf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_frame_length(in_frame_length), .in_address_key(in_address_key),
    .prefix_en(prefix_en_r), .out_free(out_free),
    .res_load(res_load), .res(res),
    .mem_req(mem_req), .mem_rdata(mem_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_verdict_drop = out_r.drop;
  assign out_match_reason = out_r.reason;
  assign out_op_status    = out_r.status;

  `SABF_ASSERT(a_drop_has_reason, out_valid |-> (out_verdict_drop == (out_match_reason != sabf_pkg::REASON_NONE)))
  `SABF_ASSERT(a_status_no_drop, (out_valid && out_op_status != sabf_pkg::STATUS_OK) |-> !out_verdict_drop)
  `SABF_ASSERT(a_load_room, res_load |-> out_free)
  `SABF_ASSERT_RST(a_reset_clears, !rst_n |=> (in_stall && !out_valid))
endmodule

// File: src/sabf_ram.sv
// Generic single-port synchronous RAM, registered read data.
// No dependencies.
module sabf_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: src/sabf_ctrl.sv
// Sequencer: clearing pass, hashing, probe windows, table updates.
// Depends on sabf_pkg.
module sabf_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [15:0]               in_frame_length,
  input  logic [31:0]               in_address_key,
  input  logic [2:0]                prefix_en,
  input  logic                      out_free,
  output logic                      res_load,
  output sabf_pkg::result_t         res,
  output sabf_pkg::mem_req_t        mem_req,
  input  logic [sabf_pkg::MEM_W-1:0] mem_rdata
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam int IW = sabf_pkg::IDX_W;
  localparam int CW = sabf_pkg::CNT_W;
  localparam logic [CW-1:0] LAST_CNT = CW'(sabf_pkg::MAX_PROBES);
  localparam logic [IW-1:0] HASH_LO = sabf_pkg::HASH_MULT[IW-1:0];

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [31:0]   addr_r, addr_nxt;   // original address of the item
  logic [31:0]   key_r, key_nxt;     // key under lookup
  logic [1:0]    stage_r, stage_nxt; // exact, /24, /16, /8
  logic [IW-1:0] home_r, home_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt;
  logic [IW-1:0] hit_slot_r, hit_slot_nxt, free_slot_r, free_slot_nxt;
  logic [IW-1:0] wr_slot_r, wr_slot_nxt;
  logic          wr_valid_r, wr_valid_nxt;
  sabf_pkg::result_t res_r, res_nxt;

  logic [2*IW-1:0] prod;
  logic [IW-1:0]   probe_addr;
  logic [2:0]      later_en;
  logic            more;
  logic [1:0]      next_stage;
  logic [31:0]     next_mask;

  assign prod       = key_r[IW-1:0] * HASH_LO;
  assign probe_addr = home_r + IW'(cnt_r);

  // next enabled prefix stage after the current one
  always_comb begin
    later_en = prefix_en;
    case (stage_r)
      2'd0:    later_en = prefix_en;
      2'd1:    later_en = {prefix_en[2:1], 1'b0};
      2'd2:    later_en = {prefix_en[2], 2'b00};
      default: later_en = 3'b000;
    endcase
    more = |later_en;
    if (later_en[0])      next_stage = 2'd1;
    else if (later_en[1]) next_stage = 2'd2;
    else                  next_stage = 2'd3;
    case (next_stage)
      2'd1:    next_mask = sabf_pkg::MASK_P24;
      2'd2:    next_mask = sabf_pkg::MASK_P16;
      default: next_mask = sabf_pkg::MASK_P8;
    endcase
  end

  always_comb begin
    state_nxt = state_r;   clr_nxt = clr_r;       cmd_nxt = cmd_r;
    addr_nxt = addr_r;     key_nxt = key_r;       stage_nxt = stage_r;
    home_nxt = home_r;     cnt_nxt = cnt_r;       prev_nxt = prev_r;
    hit_nxt = hit_r;       free_nxt = free_r;     hit_slot_nxt = hit_slot_r;
    free_slot_nxt = free_slot_r;  wr_slot_nxt = wr_slot_r;
    wr_valid_nxt = wr_valid_r;    res_nxt = res_r;
    mem_req.we    = 1'b0;
    mem_req.addr  = probe_addr;
    mem_req.wdata = '0;
    res_load = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd;
          addr_nxt = in_address_key;
          key_nxt = in_address_key;
          stage_nxt = 2'd0;
          res_nxt = '0;
          state_nxt = S_HASH;
          if (in_cmd == sabf_pkg::CMD_CHECK && in_frame_length < sabf_pkg::MIN_FRAME_BYTES)
          begin
            res_nxt.drop = 1'b1;
            res_nxt.reason = sabf_pkg::REASON_SHORT;
            state_nxt = S_OUT;
          end else if (!(in_cmd inside {sabf_pkg::CMD_CHECK, sabf_pkg::CMD_ADD,
                                        sabf_pkg::CMD_REMOVE})) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_HASH: begin
        home_nxt = prod[IW-1:0];
        cnt_nxt = '0;
        hit_nxt = 1'b0;
        free_nxt = 1'b0;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        // read data is registered, so it belongs to the address held in prev_r
        if (cnt_r != '0) begin
          if (mem_rdata[32] && mem_rdata[31:0] == key_r && !hit_r) begin
            hit_nxt = 1'b1;
            hit_slot_nxt = prev_r;
          end
          if (!mem_rdata[32] && !free_r) begin
            free_nxt = 1'b1;
            free_slot_nxt = prev_r;
          end
        end
        prev_nxt = probe_addr;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_OUT;
        case (cmd_r)
          sabf_pkg::CMD_CHECK: begin
            if (hit_r) begin
              res_nxt.drop = 1'b1;
              res_nxt.reason = sabf_pkg::REASON_EXACT + 3'(stage_r);
            end else if (more) begin
              stage_nxt = next_stage;
              key_nxt = addr_r & next_mask;
              state_nxt = S_HASH;
            end
          end
          sabf_pkg::CMD_ADD: begin
            if (!hit_r) begin
              if (free_r) begin
                wr_slot_nxt = free_slot_r;
                wr_valid_nxt = 1'b1;
                state_nxt = S_WRITE;
              end else begin
                res_nxt.status = sabf_pkg::STATUS_FULL;
              end
            end
          end
          default: begin
            if (hit_r) begin
              wr_slot_nxt = hit_slot_r;
              wr_valid_nxt = 1'b0;
              state_nxt = S_WRITE;
            end else begin
              res_nxt.status = sabf_pkg::STATUS_ABSENT;
            end
          end
        endcase
      end
      S_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = wr_slot_r;
        mem_req.wdata = {wr_valid_r, key_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;           addr_r <= addr_nxt;     key_r <= key_nxt;
    stage_r <= stage_nxt;       home_r <= home_nxt;     cnt_r <= cnt_nxt;
    prev_r <= prev_nxt;         hit_r <= hit_nxt;       free_r <= free_nxt;
    hit_slot_r <= hit_slot_nxt; free_slot_r <= free_slot_nxt;
    wr_slot_r <= wr_slot_nxt;   wr_valid_r <= wr_valid_nxt;
    res_r <= res_nxt;
  end
endmodule

// File: sim/tb_source_address_blocklist_filter.sv
// Self-checking testbench for source_address_blocklist_filter: random and
// directed check/add/remove/unused items against a predictor of the hashed blocklist.
// Depends on sabf_pkg and the RTL top level.
module tb_source_address_blocklist_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REASON_P24 = 3'd3;
  localparam logic [2:0] REASON_P16 = 3'd4;
  localparam logic [2:0] REASON_P8  = 3'd5;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] len;
    logic [31:0] addr;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [15:0] in_frame_length = '0;
  logic [31:0] in_address_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_verdict_drop;
  logic [2:0]  out_match_reason;
  logic [1:0]  out_op_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;

  source_address_blocklist_filter dut (.*);

  // predictor state
  logic [31:0] tbl_key [sabf_pkg::TABLE_ENTRIES];
  bit          tbl_used [sabf_pkg::TABLE_ENTRIES];
  logic [2:0]  prefix_en = 3'd7;

  item_t               pending_items[$];
  sabf_pkg::result_t   expected_results[$];
  logic [31:0] blocked_keys[$];   // generator's view, only steers stimulus
  logic [31:0] hot_low[4];
  int          failures = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          pushed_count = 0;
  int          checked_count = 0;
  bit          quiet = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [sabf_pkg::IDX_W-1:0] home_of(logic [31:0] key);
    logic [31:0] prod;
    prod = key * sabf_pkg::HASH_MULT;
    return prod[sabf_pkg::IDX_W-1:0];
  endfunction

  function automatic int slot_of(logic [31:0] key);
    logic [sabf_pkg::IDX_W-1:0] s;
    s = home_of(key);
    for (int i = 0; i < sabf_pkg::MAX_PROBES; i++) begin
      if (tbl_used[s] && tbl_key[s] == key) return int'(s);
      s = s + 1'b1;
    end
    return -1;
  endfunction

  function automatic sabf_pkg::result_t filter_predict(item_t it);
    sabf_pkg::result_t r;
    logic [sabf_pkg::IDX_W-1:0] s;
    int hit;
    r = '0;
    case (it.cmd)
      sabf_pkg::CMD_CHECK: begin
        if (it.len < sabf_pkg::MIN_FRAME_BYTES) r.reason = sabf_pkg::REASON_SHORT;
        else if (slot_of(it.addr) >= 0) r.reason = sabf_pkg::REASON_EXACT;
        else if (prefix_en[0] && slot_of(it.addr & sabf_pkg::MASK_P24) >= 0)
          r.reason = REASON_P24;
        else if (prefix_en[1] && slot_of(it.addr & sabf_pkg::MASK_P16) >= 0)
          r.reason = REASON_P16;
        else if (prefix_en[2] && slot_of(it.addr & sabf_pkg::MASK_P8) >= 0)
          r.reason = REASON_P8;
        else r.reason = sabf_pkg::REASON_NONE;
        r.drop = (r.reason != sabf_pkg::REASON_NONE);
      end
      sabf_pkg::CMD_ADD: begin
        if (slot_of(it.addr) < 0) begin
          r.status = sabf_pkg::STATUS_FULL;
          s = home_of(it.addr);
          for (int i = 0; i < sabf_pkg::MAX_PROBES; i++) begin
            if (r.status == sabf_pkg::STATUS_FULL && !tbl_used[s]) begin
              tbl_used[s] = 1'b1;
              tbl_key[s] = it.addr;
              r.status = sabf_pkg::STATUS_OK;
            end
            s = s + 1'b1;
          end
        end
      end
      sabf_pkg::CMD_REMOVE: begin
        hit = slot_of(it.addr);
        if (hit < 0) r.status = sabf_pkg::STATUS_ABSENT;
        else tbl_used[hit] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    item_t it;
    logic next_valid;
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        it.cmd = in_cmd;
        it.len = in_frame_length;
        it.addr = in_address_key;
        expected_results.push_back(filter_predict(it));
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 3);
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_cmd <= it.cmd;
          in_frame_length <= it.len;
          in_address_key <= it.addr;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    sabf_pkg::result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_verdict_drop !== exp_r.drop) begin
            $error("verdict_drop expected %0d actual %0d", exp_r.drop, out_verdict_drop);
            failures++;
          end
          if (out_match_reason !== exp_r.reason) begin
            $error("match_reason expected %0d actual %0d", exp_r.reason, out_match_reason);
            failures++;
          end
          if (out_op_status !== exp_r.status) begin
            $error("op_status expected %0d actual %0d", exp_r.status, out_op_status);
            failures++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_source_address_blocklist_filter NOT OK");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [15:0] len, logic [31:0] addr);
    item_t it;
    it.cmd = cmd;
    it.len = len;
    it.addr = addr;
    pending_items.push_back(it);
    pushed_count++;
    if (cmd == sabf_pkg::CMD_ADD) blocked_keys.push_back(addr);
  endtask

  // every pushed item has had its result taken
  task automatic drain();
    while (checked_count < pushed_count)
      @(posedge clk);
  endtask

  task automatic write_prefix_en(logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    prefix_en = val;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_key();
    logic [31:0] k;
    k = $urandom;
    case ($urandom_range(0, 5))
      0, 1: k[sabf_pkg::IDX_W-1:0] =
              hot_low[$urandom_range(0, 3)][sabf_pkg::IDX_W-1:0];   // same home slot
      2: k = k & sabf_pkg::MASK_P24;
      3: k = k & sabf_pkg::MASK_P16;
      4: k = k & sabf_pkg::MASK_P8;
      default: ;
    endcase
    return k;
  endfunction

  task automatic random_item();
    logic [31:0] a;
    logic [15:0] len;
    int pick;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      len = $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 33)) : 16'($urandom);
      if (len < sabf_pkg::MIN_FRAME_BYTES && $urandom_range(0, 3) != 0)
        len = 16'($urandom_range(34, 1500));
      a = $urandom;
      if (blocked_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
        a = blocked_keys[$urandom_range(0, blocked_keys.size() - 1)];
        case ($urandom_range(0, 3))
          1: a[7:0] = 8'($urandom);
          2: a[15:0] = 16'($urandom);
          3: a[23:0] = 24'($urandom);
          default: ;
        endcase
      end
      push_item(sabf_pkg::CMD_CHECK, len, a);
    end else if (sel < 78) begin
      push_item(sabf_pkg::CMD_ADD, 16'($urandom), random_key());
    end else if (sel < 95) begin
      if (blocked_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, blocked_keys.size() - 1);
        a = blocked_keys[pick];
        blocked_keys.delete(pick);
      end else begin
        a = random_key();
      end
      push_item(sabf_pkg::CMD_REMOVE, 16'($urandom), a);
    end else begin
      push_item(CMD_UNUSED, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [2:0] phase_cfg[8];
    phase_cfg = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6};
    for (int i = 0; i < sabf_pkg::TABLE_ENTRIES; i++) tbl_used[i] = 1'b0;
    for (int i = 0; i < 4; i++) hot_low[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_prefix_en(3'd7);

    // directed: frame length limits, each test in order, table corner cases
    push_item(sabf_pkg::CMD_CHECK, 16'd0, 32'h0000_0000);
    push_item(sabf_pkg::CMD_CHECK, 16'd33, 32'hFFFF_FFFF);
    push_item(sabf_pkg::CMD_CHECK, 16'd34, 32'h0000_0000);
    push_item(sabf_pkg::CMD_CHECK, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(sabf_pkg::CMD_ADD, 16'd0, 32'hFFFF_FFFF);
    push_item(sabf_pkg::CMD_ADD, 16'd0, 32'h0A00_0000);
    push_item(sabf_pkg::CMD_ADD, 16'd0, 32'h0A0B_0000);
    push_item(sabf_pkg::CMD_ADD, 16'd0, 32'h0A0B_0C00);
    push_item(sabf_pkg::CMD_ADD, 16'd0, 32'h0A0B_0C0D);
    push_item(sabf_pkg::CMD_ADD, 16'd0, 32'h0A0B_0C0D);      // already present
    push_item(sabf_pkg::CMD_CHECK, 16'd64, 32'h0A0B_0C0D);
    push_item(sabf_pkg::CMD_CHECK, 16'd64, 32'h0A0B_0C0E);
    push_item(sabf_pkg::CMD_CHECK, 16'd64, 32'h0A0B_0D01);
    push_item(sabf_pkg::CMD_CHECK, 16'd64, 32'h0A0C_0001);
    push_item(sabf_pkg::CMD_CHECK, 16'd64, 32'h0B00_0001);
    push_item(sabf_pkg::CMD_REMOVE, 16'd0, 32'h1234_5678);   // absent
    push_item(sabf_pkg::CMD_REMOVE, 16'd0, 32'h0A0B_0C0D);
    push_item(sabf_pkg::CMD_CHECK, 16'd20, 32'h0A0B_0C0D);
    push_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    // one more key than the probe window holds
    for (int i = 0; i <= sabf_pkg::MAX_PROBES; i++)
      push_item(sabf_pkg::CMD_ADD, 16'd0,
                {18'(i + 1), hot_low[0][sabf_pkg::IDX_W-1:0]});
    drain();

    for (int p = 0; p < 8; p++) begin
      write_prefix_en(phase_cfg[p]);
      quiet = (p == 7);
      repeat (110) random_item();
      drain();
    end

    repeat (100) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("tb_source_address_blocklist_filter OK");
    end else begin
      $display("tb_source_address_blocklist_filter NOT OK");
    end
    $finish;
  end
endmodule
